// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/lsmt_pkg.sv
`timescale 1ns / 1ps

package lsmt_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_MAX_PORTS   = 16;
  localparam int MAC_W           = 48;

  // Register index (address bit above the word offset)
  localparam logic REG_PORTS_PRESENT = 1'b0;
  localparam logic REG_L3_PORT_MASK  = 1'b1;

  typedef enum logic [1:0] {
    ACT_UNICAST = 2'd0,
    ACT_FLOOD   = 2'd1,
    ACT_DROP    = 2'd2
  } fwd_act_t;

  typedef enum logic [1:0] {
    LRN_SAME   = 2'd0,
    LRN_INSERT = 2'd1,
    LRN_MOVE   = 2'd2,
    LRN_FULL   = 2'd3
  } lrn_status_t;

endpackage

// File: design/lsmt_cfg.sv
`timescale 1ns / 1ps

module lsmt_cfg #(
  parameter int MAX_PORTS = lsmt_pkg::DEF_MAX_PORTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [(MAX_PORTS > 32 ? 4 : 3)-1:0]   paddr,
  input  logic [(MAX_PORTS > 32 ? 64 : 32)-1:0] pwdata,
  output logic [(MAX_PORTS > 32 ? 64 : 32)-1:0] prdata,
  output logic                                  pready,
  output logic [$clog2(MAX_PORTS+1)-1:0]        ports_present,
  output logic [MAX_PORTS-1:0]                  l3_port_mask
);
  import lsmt_pkg::*;

  localparam int DATA_W = (MAX_PORTS > 32) ? 64 : 32;
  localparam int ADDR_W = (MAX_PORTS > 32) ? 4 : 3;
  localparam int PCNT_W = $clog2(MAX_PORTS + 1);

  logic reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];   // word offset bits ignored
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ports_present <= PCNT_W'(MAX_PORTS);
      l3_port_mask  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PORTS_PRESENT: ports_present <= pwdata[PCNT_W-1:0];
        REG_L3_PORT_MASK:  l3_port_mask  <= pwdata[MAX_PORTS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PORTS_PRESENT: prdata = DATA_W'(ports_present);
      REG_L3_PORT_MASK:  prdata = DATA_W'(l3_port_mask);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: design/learning_switch_mac_table.sv
`timescale 1ns / 1ps
// A request is accepted in idle, scanned against the filled entries, then decided and written back;
// the result is registered at write-back. One request at a time: the input stalls until idle again.
// The scan runs through the single-read-port MAC memory, one entry per cycle.
// A waiting result lets the next request in and scanned; its write-back waits for the result.
// Reset (rst, synchronous): fill count cleared (table empty), registers to MAX_PORTS ports / no L3.
// No clearing pass: the table fills contiguously, so the fill count marks valid entries.

module learning_switch_mac_table #(
  parameter int TABLE_DEPTH = lsmt_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_PORTS   = lsmt_pkg::DEF_MAX_PORTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [(MAX_PORTS > 32 ? 4 : 3)-1:0]   paddr,
  input  logic [(MAX_PORTS > 32 ? 64 : 32)-1:0] pwdata,
  output logic [(MAX_PORTS > 32 ? 64 : 32)-1:0] prdata,
  output logic                                  pready,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lsmt_pkg::MAC_W-1:0]            src_mac,
  input  logic [lsmt_pkg::MAC_W-1:0]            dst_mac,
  input  logic [$clog2(MAX_PORTS)-1:0]          ingress_port,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [MAX_PORTS-1:0]                  egress_mask,
  output logic [1:0]                            forward_action,
  output logic [1:0]                            learn_status
);
  import lsmt_pkg::*;

  `include "assert_macros.svh"

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PORT_W = $clog2(MAX_PORTS);
  localparam int PCNT_W = $clog2(MAX_PORTS + 1);
  localparam int WORD_W = MAC_W + PORT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PCNT_W-1:0]    ports_present;
  logic [MAX_PORTS-1:0] l3_port_mask;

  lsmt_cfg #(
    .MAX_PORTS (MAX_PORTS)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .ports_present (ports_present),
    .l3_port_mask  (l3_port_mask)
  );

  // ---------------------------------------------------------------------------
  // Control and request registers
  // ---------------------------------------------------------------------------
  state_t            state;
  logic [CNT_W-1:0]  fill_count;   // entries 0..fill_count-1 are valid
  logic [CNT_W-1:0]  scan_idx;     // next entry to read
  logic              rd_vld;       // rd_word holds entry rd_idx
  logic [IDX_W-1:0]  rd_idx;

  logic [MAC_W-1:0]  req_src;
  logic [MAC_W-1:0]  req_dst;
  logic [PORT_W-1:0] req_port;

  // scan results
  logic              src_hit;
  logic [IDX_W-1:0]  src_idx;
  logic [PORT_W-1:0] src_port;
  logic              dst_hit;
  logic [PORT_W-1:0] dst_port;

  fwd_act_t          act_q;
  lrn_status_t       lrn_q;

  // ---------------------------------------------------------------------------
  // Table memory: {mac, port} per entry, one read and one write port
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[rd_addr];
  end

  logic [MAC_W-1:0]  rd_mac;
  logic [PORT_W-1:0] rd_port;
  assign rd_mac  = rd_word[WORD_W-1:PORT_W];
  assign rd_port = rd_word[PORT_W-1:0];

  // ---------------------------------------------------------------------------
  // Scan control
  // ---------------------------------------------------------------------------
  logic issuing;
  logic accept;
  logic out_hold;

  assign issuing  = (state == S_SCAN) && (scan_idx < fill_count);
  assign rd_addr  = scan_idx[IDX_W-1:0];
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;

  // ---------------------------------------------------------------------------
  // Learn / forward decision (write-back cycle)
  // ---------------------------------------------------------------------------
  logic [MAX_PORTS-1:0] present;
  logic [MAX_PORTS-1:0] avail;
  logic [MAX_PORTS-1:0] ing_bit;
  logic [MAX_PORTS-1:0] fwd_bit;
  logic                 table_full;
  logic                 dst_bcast;
  logic                 dst_is_src;
  logic                 dst_known;
  logic [PORT_W-1:0]    fwd_port;
  lrn_status_t          lrn_next;
  fwd_act_t             act_next;
  logic [MAX_PORTS-1:0] egress_next;

  always_comb begin
    // port count above MAX_PORTS covers every port anyway
    for (int p = 0; p < MAX_PORTS; p++) begin
      present[p] = (ports_present > PCNT_W'(p));
    end
  end

  assign avail      = present & ~l3_port_mask;
  assign ing_bit    = MAX_PORTS'(1) << req_port;
  assign table_full = (fill_count == CNT_W'(TABLE_DEPTH));
  assign dst_bcast  = &req_dst;
  assign dst_is_src = (req_dst == req_src);

  always_comb begin
    priority if (src_hit) begin
      lrn_next = (src_port == req_port) ? LRN_SAME : LRN_MOVE;
    end else if (table_full) begin
      lrn_next = LRN_FULL;
    end else begin
      lrn_next = LRN_INSERT;
    end
  end

  // learning runs first: a destination equal to the source sees the new port
  assign dst_known = !dst_bcast && (dst_hit || (dst_is_src && (lrn_next != LRN_FULL)));
  assign fwd_port  = dst_is_src ? req_port : dst_port;
  assign fwd_bit   = MAX_PORTS'(1) << fwd_port;

  always_comb begin
    priority if (!dst_known) begin
      act_next    = ACT_FLOOD;
      egress_next = avail & ~ing_bit;
    end else if ((avail & fwd_bit) != '0) begin
      act_next    = ACT_UNICAST;
      egress_next = fwd_bit;
    end else begin
      act_next    = ACT_DROP;
      egress_next = '0;
    end
  end

  // write-back happens together with the result load
  assign mem_we    = (state == S_WRITE) && !out_hold &&
                     ((lrn_next == LRN_INSERT) || (lrn_next == LRN_MOVE));
  assign mem_waddr = (lrn_next == LRN_MOVE) ? src_idx : fill_count[IDX_W-1:0];
  assign mem_wdata = {req_src, req_port};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // write-back reloads the result register itself
      if (out_valid && !out_stall && (state != S_WRITE)) begin
        out_valid <= 1'b0;
      end
      rd_vld <= issuing;
      rd_idx <= rd_addr;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_src  <= src_mac;
            req_dst  <= dst_mac;
            req_port <= ingress_port;
            src_hit  <= 1'b0;
            dst_hit  <= 1'b0;
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (rd_vld) begin
            if (rd_mac == req_src) begin
              src_hit  <= 1'b1;
              src_idx  <= rd_idx;
              src_port <= rd_port;
            end
            if (rd_mac == req_dst) begin
              dst_hit  <= 1'b1;
              dst_port <= rd_port;
            end
          end
          if (!issuing && !rd_vld) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (!out_hold) begin
            out_valid   <= 1'b1;
            egress_mask <= egress_next;
            act_q       <= act_next;
            lrn_q       <= lrn_next;
            if (lrn_next == LRN_INSERT) begin
              fill_count <= fill_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign forward_action = act_q;
  assign learn_status   = lrn_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_fill_bound, fill_count <= CNT_W'(TABLE_DEPTH), "fill count beyond table depth")
  `ASSERT_NEXT(a_accept_busy, accept, in_stall && !issuing || state == S_SCAN, "accept did not start scan")
  `ASSERT_SAME(a_fill_on_insert, (fill_count != $past(fill_count)) && !$past(rst), out_valid && (learn_status == LRN_INSERT), "fill count moved without insert")
  `ASSERT_SAME(a_result_from_wb, $rose(out_valid), $past(state) == S_WRITE, "result loaded outside write-back")

endmodule

// File: dv/mac_table_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both request/result channels, keeps its own copy of the
// MAC table, predicts each result and compares it with what comes out.
module mac_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [47:0] src_mac,
  input  logic [47:0] dst_mac,
  input  logic [3:0]  ingress_port,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] egress_mask,
  input  logic [1:0]  forward_action,
  input  logic [1:0]  learn_status,
  input  logic        run_done,
  output int          pending,
  output int          errors
);
  import lsmt_pkg::*;

  typedef struct packed {
    logic [15:0] egress;
    fwd_act_t    act;
    lrn_status_t lrn;
  } fwd_result_t;

  localparam int DEPTH = DEF_TABLE_DEPTH;

  logic [4:0]  cfg_ports;
  logic [15:0] cfg_l3;
  logic        tbl_valid [DEPTH];
  logic [47:0] tbl_mac   [DEPTH];
  logic [3:0]  tbl_port  [DEPTH];
  fwd_result_t fwd_due [$];
  logic        leftover_done;

  initial errors = 0;

  task automatic note_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int table_index(input logic [47:0] mac);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) return i;
    return -1;
  endfunction

  // Learn the source, then pick the egress ports for the frame.
  function automatic fwd_result_t forward_frame(input logic [47:0] s, input logic [47:0] d,
                                                input logic [3:0] p);
    fwd_result_t r;
    int          hit;
    int          slot;
    logic [4:0]  n;
    logic [15:0] open_ports;
    hit = table_index(s);
    if (hit >= 0) begin
      if (tbl_port[hit] == p) begin
        r.lrn = LRN_SAME;
      end else begin
        tbl_port[hit] = p;
        r.lrn = LRN_MOVE;
      end
    end else begin
      slot = -1;
      for (int i = DEPTH - 1; i >= 0; i--)
        if (!tbl_valid[i]) slot = i;
      if (slot < 0) begin
        r.lrn = LRN_FULL;
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_mac[slot]   = s;
        tbl_port[slot]  = p;
        r.lrn = LRN_INSERT;
      end
    end
    n = (cfg_ports > 5'd16) ? 5'd16 : cfg_ports;
    open_ports = 16'((17'd1 << n) - 17'd1) & ~cfg_l3;
    hit = (d == '1) ? -1 : table_index(d);
    if (hit < 0) begin
      r.egress = open_ports & ~(16'd1 << p);
      r.act    = ACT_FLOOD;
    end else if (open_ports[tbl_port[hit]]) begin
      r.egress = 16'd1 << tbl_port[hit];
      r.act    = ACT_UNICAST;
    end else begin
      r.egress = '0;
      r.act    = ACT_DROP;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    fwd_result_t want;
    if (rst) begin
      cfg_ports     <= 5'd16;
      cfg_l3        <= '0;
      leftover_done <= 1'b0;
      for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
      fwd_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_PORTS_PRESENT: cfg_ports <= pwdata[4:0];
          REG_L3_PORT_MASK:  cfg_l3    <= pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (fwd_due.size() == 0) begin
          note_mismatch($sformatf("result with nothing outstanding: mask %h act %0d lrn %0d",
                                  egress_mask, forward_action, learn_status));
        end else begin
          want = fwd_due.pop_front();
          if (egress_mask !== want.egress)
            note_mismatch($sformatf("egress_mask got %h want %h", egress_mask, want.egress));
          if (forward_action !== want.act)
            note_mismatch($sformatf("forward_action got %0d want %0d", forward_action,
                                    want.act));
          if (learn_status !== want.lrn)
            note_mismatch($sformatf("learn_status got %0d want %0d", learn_status, want.lrn));
        end
      end
      if (in_valid && !in_stall)
        fwd_due.push_back(forward_frame(src_mac, dst_mac, ingress_port));
      if (run_done && !leftover_done) begin
        leftover_done <= 1'b1;
        if (fwd_due.size() != 0)
          note_mismatch($sformatf("%0d results never arrived", fwd_due.size()));
      end
    end
    pending <= fwd_due.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

// Top of the MAC table bench: clock, reset, request stimulus, result back-pressure and
// the verdict. All checking lives in mac_table_checker.
module testbench;
  import lsmt_pkg::*;

  localparam int NUM_MACS   = 40;    // more than the table holds, so it ends up full
  localparam int CYCLE_CAP  = 200000;
  localparam int HOLD_AT    = 200;   // request count where the long result hold starts
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_AT   = 350;   // request count where the sender drains the block

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [47:0] src_mac = '0;
  logic [47:0] dst_mac = '0;
  logic [3:0]  ingress_port = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] egress_mask;
  logic [1:0]  forward_action;
  logic [1:0]  learn_status;

  logic        run_done = 1'b0;
  logic        long_hold = 1'b0;
  int          idle_pct = 0;       // chance per slot of an idle burst, both sides
  int          stall_left = 0;
  int          pending;
  int          errors;
  int          n_sent = 0;
  int          cycles = 0;

  logic [47:0] mac_pool  [NUM_MACS];
  logic [3:0]  home_port [NUM_MACS];

  always #5 clk = ~clk;

  learning_switch_mac_table u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .src_mac        (src_mac),
    .dst_mac        (dst_mac),
    .ingress_port   (ingress_port),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .egress_mask    (egress_mask),
    .forward_action (forward_action),
    .learn_status   (learn_status)
  );

  mac_table_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .src_mac        (src_mac),
    .dst_mac        (dst_mac),
    .ingress_port   (ingress_port),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .egress_mask    (egress_mask),
    .forward_action (forward_action),
    .learn_status   (learn_status),
    .run_done       (run_done),
    .pending        (pending),
    .errors         (errors)
  );

  // Watchdog: several times what the slowest legal run needs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("learning_switch_mac_table verification failed");
      $finish;
    end
  end

  // Result side back-pressure: short random bursts, or the long hold when it is on.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long hold on results, counted here, while the sender keeps offering requests so the
  // block backs up and stalls its input.
  initial begin
    wait (n_sent >= HOLD_AT);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Called at a rising edge. Leaves in_valid high so back-to-back requests keep it up.
  task automatic send_req(input logic [47:0] s, input logic [47:0] d, input logic [3:0] p);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    src_mac      <= s;
    dst_mac      <= d;
    ingress_port <= p;
    // inputs only move at rising edges, so the stall seen at the falling edge holds
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    n_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering requests and wait until every result is back.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Registers only change while the block is idle.
  task automatic configure(input logic [4:0] nports, input logic [15:0] l3);
    drain();
    write_reg(REG_PORTS_PRESENT, 32'(nports));
    write_reg(REG_L3_PORT_MASK, 32'(l3));
  endtask

  // Mostly known stations on their home port; some moves, strangers and broadcasts.
  task automatic random_frame(output logic [47:0] s, output logic [47:0] d,
                              output logic [3:0] p);
    int k;
    int roll;
    k = $urandom_range(0, NUM_MACS - 1);
    if ($urandom_range(0, 99) < 8) begin
      s = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
      p = 4'($urandom);
    end else begin
      s = mac_pool[k];
      p = ($urandom_range(0, 99) < 75) ? home_port[k] : 4'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 55)
      d = mac_pool[$urandom_range(0, NUM_MACS - 1)];
    else if (roll < 70)
      d = '1;
    else
      d = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
  endtask

  task automatic random_phase(input int count, input int pct, input logic [4:0] nports,
                              input logic [15:0] l3);
    logic [47:0] s;
    logic [47:0] d;
    logic [3:0]  p;
    configure(nports, l3);
    idle_pct <= pct;
    for (int i = 0; i < count; i++) begin
      // one pause mid-run where the sender waits for the block to empty
      if (n_sent == DRAIN_AT) drain();
      random_frame(s, d, p);
      send_req(s, d, p);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_MACS; i++) begin
      mac_pool[i]  = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
      home_port[i] = 4'($urandom);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed: default config, 16 ports, no L3
    idle_pct <= 25;
    send_req(48'h0200_0000_000A, '1, 4'd0);                   // insert, broadcast flood
    send_req(48'h0200_0000_000B, 48'h0200_0000_000A, 4'd5);   // insert, unicast to 0
    send_req(48'h0200_0000_000A, 48'h0200_0000_000B, 4'd3);   // port move, unicast to 5
    send_req(48'h0200_0000_000A, 48'h0200_0000_000A, 4'd3);   // src == dst, back to ingress
    send_req('1, 48'h0200_0000_00CC, 4'd15);                  // broadcast source learned
    send_req(48'h0, '1, 4'd15);                               // learned all-ones still floods
    send_req(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 4'd10);  // unknown dst floods

    // ---- four ports, port 1 in L3 mode
    configure(5'd4, 16'h0002);
    send_req(48'h0200_0000_000D, 48'h0200_0000_000B, 4'd1);   // dst port 5 absent: drop
    send_req(48'h0200_0000_000E, 48'h0200_0000_000D, 4'd2);   // dst port 1 in L3: drop
    send_req(48'h0200_0000_000F, 48'h0200_0000_00EE, 4'd9);   // absent ingress, flood
    send_req(48'h0200_0000_0010, 48'h0200_0000_000F, 4'd0);   // learned on absent port
    send_req(48'h0200_0000_0011, 48'h0200_0000_000A, 4'd3);   // unicast to 3

    // ---- no ports at all: floods are empty but still flagged as flooded
    configure(5'd0, 16'h0000);
    send_req(48'h0200_0000_0012, '1, 4'd2);
    send_req(48'h0200_0000_0013, 48'h0200_0000_000A, 4'd2);

    // ---- port count beyond the maximum, every port in L3 mode
    configure(5'd31, 16'hFFFF);
    send_req(48'h0200_0000_0014, 48'h5555_5555_5555, 4'd7);
    send_req(48'h0200_0000_0015, 48'h0200_0000_000A, 4'd7);

    // ---- count just past the maximum, edge ports in L3
    configure(5'd17, 16'h8001);
    send_req(48'h0200_0000_0016, '1, 4'd4);
    send_req(48'h0200_0000_0017, 48'h0200_0000_0010, 4'd15);  // unicast to 0 is L3: drop

    // ---- random phases; the table fills early and then reports full for strangers
    random_phase(120, 25, 5'd16, 16'h0000);
    random_phase(120, 40, 5'($urandom_range(1, 16)), 16'($urandom));
    random_phase(120, 30, 5'($urandom_range(17, 31)), 16'($urandom));
    random_phase(120, 0, 5'd1, 16'h0000);                     // stretch with no idling
    random_phase(120, 0, 5'($urandom_range(2, 16)), 16'($urandom) & 16'h00FF);

    // ---- wrap up: drain, let the pipeline settle, flag anything still outstanding
    drain();
    repeat (DEF_TABLE_DEPTH + 5) @(posedge clk);
    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (errors == 0) begin
      $display("learning_switch_mac_table verification clean");
    end else begin
      $display("learning_switch_mac_table verification failed");
    end
    $finish;
  end

endmodule
